### sv/integer_matrix_multiply_defines.svh
// assertion macros for the integer matrix multiply block
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/imm_pkg.sv
// shared types and constants for the integer matrix multiply block
package imm_pkg;

  localparam int CMD_W       = 2;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 36;
  localparam int DIM_REG_W   = 4;
  localparam int CFG_IDX_W   = 2;

  localparam int IMM_MAX_DIM   = 8;
  localparam int IMM_ELEM_BITS = 16;

  localparam logic [DIM_REG_W-1:0] ROWS_A_RST    = 4'd3;
  localparam logic [DIM_REG_W-1:0] INNER_LEN_RST = 4'd3;
  localparam logic [DIM_REG_W-1:0] COLS_B_RST    = 4'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_LEN = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } state_t;

  // one issued multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_issue_t;

endpackage

### sv/imm_in_if.sv
// input channel: load and compute commands
interface imm_in_if;
  logic                                valid;
  logic                                ready;
  logic [imm_pkg::CMD_W-1:0]           command;
  logic [imm_pkg::ROW_W-1:0]           row;
  logic [imm_pkg::COL_W-1:0]           col;
  logic signed [imm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

### sv/imm_out_if.sv
// result channel: one entry of the product matrix per beat
interface imm_out_if;
  logic                                valid;
  logic                                ready;
  logic [imm_pkg::ROW_W-1:0]           out_row;
  logic [imm_pkg::COL_W-1:0]           out_col;
  logic signed [imm_pkg::PROD_W-1:0]   product;
  logic                                last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

### sv/imm_ram.sv
// single write port, single registered read port matrix store
module imm_ram #(
  parameter  int DEPTH  = imm_pkg::IMM_MAX_DIM * imm_pkg::IMM_MAX_DIM,
  parameter  int WIDTH  = imm_pkg::IMM_ELEM_BITS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/imm_mac.sv
// shared multiply-accumulate unit: registered multiply, then accumulate
module imm_mac #(
  parameter int ELEM_BITS = imm_pkg::IMM_ELEM_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  imm_pkg::mac_issue_t               issue,
  input  logic signed [ELEM_BITS-1:0]       a,
  input  logic signed [ELEM_BITS-1:0]       b,
  output logic signed [imm_pkg::PROD_W-1:0] acc,
  output logic                              done
);

  localparam int MUL_W = 2 * ELEM_BITS;

  imm_pkg::mac_issue_t          s1_r, s2_r;
  logic signed [MUL_W-1:0]      prod_r, prod_nxt;
  logic signed [imm_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic                         done_r;

  // ram data lines up with s1, product with s2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= issue;
      s2_r   <= s1_r;
      done_r <= s2_r.valid & s2_r.last;
    end
  end

  always_comb begin
    prod_nxt = a * b;
    acc_nxt  = acc_r;
    if (s2_r.valid) begin
      acc_nxt = s2_r.first ? imm_pkg::PROD_W'(prod_r)
                           : acc_r + imm_pkg::PROD_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r.valid) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

### sv/imm_ctrl.sv
// sequencer: walks i, j, k and steps the shared multiply-accumulate unit
module imm_ctrl #(
  parameter  int MAX_DIM = imm_pkg::IMM_MAX_DIM,
  localparam int IDX_W   = $clog2(MAX_DIM),
  localparam int DIM_W   = $clog2(MAX_DIM + 1),
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      out_ready,
  input  logic                      done,
  input  logic [DIM_W-1:0]          n_dim,
  input  logic [DIM_W-1:0]          p_dim,
  input  logic [DIM_W-1:0]          m_dim,
  output logic                      in_ready,
  output logic                      out_valid,
  output logic [imm_pkg::ROW_W-1:0] out_row,
  output logic [imm_pkg::COL_W-1:0] out_col,
  output logic                      out_last,
  output logic [ADDR_W-1:0]         a_addr,
  output logic [ADDR_W-1:0]         b_addr,
  output imm_pkg::mac_issue_t       issue
);

  imm_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             k_last, i_last, j_last;

  assign k_last = DIM_W'(k_r) == p_dim - DIM_W'(1);
  assign i_last = DIM_W'(i_r) == n_dim - DIM_W'(1);
  assign j_last = DIM_W'(j_r) == m_dim - DIM_W'(1);

  assign a_addr = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_addr = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    issue       = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      imm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = imm_pkg::ST_RUN;
        end
      end
      imm_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = k_r == '0;
        issue.last  = k_last;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = imm_pkg::ST_WAIT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      imm_pkg::ST_WAIT: begin
        if (done) begin
          state_nxt = imm_pkg::ST_OUT;
        end
      end
      imm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          priority if (i_last && j_last) begin
            state_nxt = imm_pkg::ST_IDLE;
          end else if (j_last) begin
            j_nxt     = '0;
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = imm_pkg::ST_RUN;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = imm_pkg::ST_RUN;
          end
        end
      end
      default: state_nxt = imm_pkg::ST_IDLE;
    endcase
  end

  assign out_row  = imm_pkg::ROW_W'(i_r);
  assign out_col  = imm_pkg::COL_W'(j_r);
  assign out_last = i_last && j_last;

endmodule

### sv/integer_matrix_multiply.sv
// integer matrix multiply top level: C = A * B over a shared multiply-accumulate unit
// a load beat is accepted back to back while the block is idle; it yields no result
// a compute beat runs n*m entries, each through ram read, multiply and
// accumulate, then a result beat that is held until out_ready accepts it
// the single multiplier and the one read port per store serve the entries in turn
// reset: dims go to 3, 3, 4; stores keep no reset and are undefined until written
`include "integer_matrix_multiply_defines.svh"

module integer_matrix_multiply #(
  parameter int MAX_DIM   = imm_pkg::IMM_MAX_DIM,
  parameter int ELEM_BITS = imm_pkg::IMM_ELEM_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::DIM_REG_W-1:0] cfg_data,
  imm_in_if.sink                        in_ch,
  imm_out_if.source                     out_ch
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers, kept at their written bits
  logic [imm_pkg::DIM_REG_W-1:0] rows_a_r, inner_len_r, cols_b_r;
  logic [DIM_W-1:0]              n_dim, p_dim, m_dim;

  // load path
  logic                    in_beat, load_ok, we_a, we_b, start;
  logic [ADDR_W-1:0]       waddr;
  logic [ELEM_BITS-1:0]    wdata;

  // read path into the shared unit
  logic [ADDR_W-1:0]       a_addr, b_addr;
  logic [ELEM_BITS-1:0]    a_data, b_data;
  imm_pkg::mac_issue_t     issue;
  logic signed [imm_pkg::PROD_W-1:0] acc;
  logic                    done;

  // zero counts as one, anything past the store size as the store size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [imm_pkg::DIM_REG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (int'(r) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= imm_pkg::ROWS_A_RST;
      inner_len_r <= imm_pkg::INNER_LEN_RST;
      cols_b_r    <= imm_pkg::COLS_B_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        imm_pkg::REG_ROWS_A:    rows_a_r    <= cfg_data;
        imm_pkg::REG_INNER_LEN: inner_len_r <= cfg_data;
        imm_pkg::REG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;  // index past the list does nothing
      endcase
    end
  end

  assign n_dim = clamp_dim(rows_a_r);
  assign p_dim = clamp_dim(inner_len_r);
  assign m_dim = clamp_dim(cols_b_r);

  // decode of the input beat; loads outside the store are dropped
  assign in_beat = in_ch.valid && in_ch.ready;
  assign load_ok = (int'(in_ch.row) < MAX_DIM) && (int'(in_ch.col) < MAX_DIM);
  assign we_a    = in_beat && load_ok && (in_ch.command == imm_pkg::CMD_LOAD_A);
  assign we_b    = in_beat && load_ok && (in_ch.command == imm_pkg::CMD_LOAD_B);
  assign start   = in_beat && (in_ch.command == imm_pkg::CMD_COMPUTE);
  assign waddr   = ADDR_W'(int'(in_ch.row[IDX_W-1:0]) * MAX_DIM
                         + int'(in_ch.col[IDX_W-1:0]));
  // narrow elements keep the low bits, wide ones sign extend
  assign wdata   = ELEM_BITS'(in_ch.value);

  imm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_addr),
    .rdata (a_data)
  );

  imm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_addr),
    .rdata (b_data)
  );

  imm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .a     (signed'(a_data)),
    .b     (signed'(b_data)),
    .acc   (acc),
    .done  (done)
  );

  // sequencer owns the handshakes; result payload comes straight off registers
  imm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .out_ready (out_ch.ready),
    .done      (done),
    .n_dim     (n_dim),
    .p_dim     (p_dim),
    .m_dim     (m_dim),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_last  (out_ch.last),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .issue     (issue)
  );

  // accumulator holds the finished sum for the whole result beat
  assign out_ch.product = acc;

  // no new command while a result beat is offered
  `IMM_ASSERT_NOW(a_ready_excl, in_ch.ready, !out_ch.valid, "input ready during result beat")
  // a compute beat closes the input side
  `IMM_ASSERT_NEXT(a_start_busy, start, !in_ch.ready, "ready after compute beat")
  // the final result beat frees the block
  `IMM_ASSERT_NEXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.last, in_ch.ready,
                   "not ready after final result beat")
  // result coordinates stay inside the configured matrix
  `IMM_ASSERT_NOW(a_coord, out_ch.valid,
                  (int'(out_ch.out_row) < int'(n_dim)) && (int'(out_ch.out_col) < int'(m_dim)),
                  "result coordinate outside matrix")

endmodule
